// ===== hdl/mwsm_pkg.sv =====
package mwsm_pkg;

	// configuration port geometry
	localparam int unsigned CFG_DATA_W = 24;
	localparam int unsigned CFG_IDX_W  = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROT_BASE      = 3'd0,
		CFG_ROT_OFFSET    = 3'd1,
		CFG_RPM_PER_SPEED = 3'd2,
		CFG_MAX_FORWARD   = 3'd3,
		CFG_MAX_SIDE      = 3'd4,
		CFG_MAX_YAW       = 3'd5,
		CFG_MAX_WHEEL_RPM = 3'd6
	} cfg_idx_t;

	// wheel order: front right, front left, back left, back right
	localparam int unsigned NUM_WHEELS = 4;
	localparam int unsigned WHEEL_W    = 16;

	// proportional scaling divider
	localparam int unsigned QUO_W          = 15;
	localparam int unsigned DIVD_W         = 30;
	localparam int unsigned DSOR_W         = 16;
	localparam int unsigned BITS_PER_STAGE = 3;
	localparam int unsigned DIV_STAGES     = QUO_W / BITS_PER_STAGE;

	typedef struct packed {
		logic [DIVD_W-1:0] rem;
		logic [QUO_W-1:0]  quo;
	} div_lane_t;

	typedef struct packed {
		div_lane_t [NUM_WHEELS-1:0]            lane;
		logic [DSOR_W-1:0]                     divisor;
		logic [NUM_WHEELS-1:0]                 neg;
		logic                                  scaled;
		logic [NUM_WHEELS-1:0][WHEEL_W-1:0]    wheel;
	} div_stage_t;

endpackage

// ===== hdl/mwsm_if.sv =====
interface mwsm_cmd_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] forward_speed;
	logic signed [15:0] side_speed;
	logic signed [15:0] yaw_rate;
	logic               shift_center;

	modport source (output valid, output forward_speed, output side_speed,
		output yaw_rate, output shift_center, input ready);
	modport sink (input valid, input forward_speed, input side_speed,
		input yaw_rate, input shift_center, output ready);
endinterface

interface mwsm_wheel_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] wheel_front_right;
	logic signed [15:0] wheel_front_left;
	logic signed [15:0] wheel_back_left;
	logic signed [15:0] wheel_back_right;
	logic               was_scaled;

	modport source (output valid, output wheel_front_right, output wheel_front_left,
		output wheel_back_left, output wheel_back_right, output was_scaled,
		input ready);
	modport sink (input valid, input wheel_front_right, input wheel_front_left,
		input wheel_back_left, input wheel_back_right, input was_scaled,
		output ready);
endinterface

// ===== hdl/mecanum_wheel_speed_mixer_top.sv =====
// Mecanum wheel speed mixer. Each command item (forward speed, side speed, yaw rate, dodge
// flag) gives one result item: four wheel rpm references and a flag that tells whether the
// set was scaled down to the wheel rpm limit. The datapath is a 13 stage pipeline that takes
// one item per clock while the output side is not stalled; the first stage is loaded at the
// accepting edge. The depth is set by the rpm multiply chain (clamp, yaw product, sum,
// 34x24 rpm product, truncate and saturate, peak search, scaling product), then a five stage
// restoring divider that yields three quotient bits per stage for all four wheels at once,
// and an output stage. Every stage has its own valid bit, so a stalled output only holds back
// the stages behind it and bubbles are squeezed out. Configuration registers are written
// through a plain write port and should only change while no item is in flight.
module mecanum_wheel_speed_mixer_top
	import mwsm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	mwsm_cmd_if.sink              cmd,
	mwsm_wheel_if.source          wheel
);

	localparam int unsigned NSTG = 8 + DIV_STAGES;

	// configuration reset values
	localparam logic [15:0] ROT_BASE_RST  = 16'd1792;
	localparam logic [15:0] ROT_OFF_RST   = 16'd0;
	localparam logic [23:0] RPM_RST       = 24'd65536;
	localparam logic [14:0] MAX_FWD_RST   = 15'd3500;
	localparam logic [14:0] MAX_SIDE_RST  = 15'd3500;
	localparam logic [14:0] MAX_YAW_RST   = 15'd300;
	localparam logic [14:0] MAX_WHEEL_RST = 15'd8500;

	// configuration registers
	logic [15:0] rot_base_q;
	logic [15:0] rot_off_q;
	logic [23:0] rpm_per_speed_q;
	logic [14:0] max_fwd_q;
	logic [14:0] max_side_q;
	logic [14:0] max_yaw_q;
	logic [14:0] max_wheel_rpm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_base_q      <= ROT_BASE_RST;
			rot_off_q       <= ROT_OFF_RST;
			rpm_per_speed_q <= RPM_RST;
			max_fwd_q       <= MAX_FWD_RST;
			max_side_q      <= MAX_SIDE_RST;
			max_yaw_q       <= MAX_YAW_RST;
			max_wheel_rpm_q <= MAX_WHEEL_RST;
		end else if (wr_en) begin
			unique case (cfg_idx_t'(wr_index))
				CFG_ROT_BASE:      rot_base_q      <= wr_data[15:0];
				CFG_ROT_OFFSET:    rot_off_q       <= wr_data[15:0];
				CFG_RPM_PER_SPEED: rpm_per_speed_q <= wr_data[23:0];
				CFG_MAX_FORWARD:   max_fwd_q       <= wr_data[14:0];
				CFG_MAX_SIDE:      max_side_q      <= wr_data[14:0];
				CFG_MAX_YAW:       max_yaw_q       <= wr_data[14:0];
				CFG_MAX_WHEEL_RPM: max_wheel_rpm_q <= wr_data[14:0];
				default: ;
			endcase
		end
	end

	// symmetric clamp, limit is at most 32767 so its negation fits 16 bits
	function automatic logic signed [15:0] clamp_sym(logic signed [15:0] v, logic [14:0] lim);
		logic signed [15:0] hi;
		logic signed [15:0] lo;
		hi = $signed({1'b0, lim});
		lo = -hi;
		if (v > hi) begin
			clamp_sym = hi;
		end else if (v < lo) begin
			clamp_sym = lo;
		end else begin
			clamp_sym = v;
		end
	endfunction

	// valid bits and per-stage advance
	logic                  vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s13;
	logic [DIV_STAGES-1:0] div_vld;
	logic [NSTG:0]         vld;
	logic [NSTG:1]         en;

	assign vld = {vld_s13, div_vld, vld_s7, vld_s6, vld_s5, vld_s4, vld_s3, vld_s2, vld_s1,
		cmd.valid};

	// a stage may load when it is empty or its content moves on
	always_comb begin
		en[NSTG] = !vld[NSTG] || wheel.ready;
		for (int k = NSTG - 1; k >= 1; k--) begin
			en[k] = !vld[k] || en[k+1];
		end
	end

	assign cmd.ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s13 <= 1'b0;
		end else begin
			if (en[1]) vld_s1 <= vld[0];
			if (en[2]) vld_s2 <= vld[1];
			if (en[3]) vld_s3 <= vld[2];
			if (en[4]) vld_s4 <= vld[3];
			if (en[5]) vld_s5 <= vld[4];
			if (en[6]) vld_s6 <= vld[5];
			if (en[7]) vld_s7 <= vld[6];
			if (en[NSTG]) vld_s13 <= vld[NSTG-1];
		end
	end

	// s1: clamp the commands
	logic signed [15:0] vx_s1, vy_s1, vw_s1;
	logic               dodge_s1;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			vx_s1    <= clamp_sym(cmd.forward_speed, max_fwd_q);
			vy_s1    <= clamp_sym(cmd.side_speed, max_side_q);
			vw_s1    <= clamp_sym(cmd.yaw_rate, max_yaw_q);
			dodge_s1 <= cmd.shift_center;
		end
	end

	// s2: linear terms and yaw products for front and rear ratios
	logic signed [17:0] lin_s2 [NUM_WHEELS];
	logic signed [33:0] prod_f_s2, prod_r_s2;
	logic signed [17:0] rf_c, rr_c, off_c, ex_c, ey_c;

	always_comb begin
		off_c = dodge_s1 ? $signed({2'b0, rot_off_q}) : 18'sd0;
		rf_c  = $signed({2'b0, rot_base_q}) - off_c;
		rr_c  = $signed({2'b0, rot_base_q}) + off_c;
		ex_c  = 18'(vx_s1);
		ey_c  = 18'(vy_s1);
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			lin_s2[0] <= -ex_c + ey_c;
			lin_s2[1] <=  ex_c + ey_c;
			lin_s2[2] <= -ex_c - ey_c;
			lin_s2[3] <=  ex_c - ey_c;
			prod_f_s2 <= 34'(vw_s1) * 34'(rf_c);
			prod_r_s2 <= 34'(vw_s1) * 34'(rr_c);
		end
	end

	// s3: Q8 linear wheel speed
	logic signed [33:0] s_s3 [NUM_WHEELS];

	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int i = 0; i < NUM_WHEELS; i++) begin
				s_s3[i] <= (34'(lin_s2[i]) <<< 8) + ((i < 2) ? prod_f_s2 : prod_r_s2);
			end
		end
	end

	// s4: rpm factor product
	logic signed [57:0] p_s4 [NUM_WHEELS];

	always_ff @(posedge clk) begin
		if (en[4]) begin
			for (int i = 0; i < NUM_WHEELS; i++) begin
				p_s4[i] <= 58'(s_s3[i]) * $signed(58'({1'b0, rpm_per_speed_q}));
			end
		end
	end

	// s5: drop 24 fraction bits toward zero, saturate to 16 bits
	logic signed [15:0] w_s5 [NUM_WHEELS];
	logic signed [15:0] w_c  [NUM_WHEELS];

	always_comb begin
		logic signed [57:0] padj;
		logic signed [33:0] q;
		for (int i = 0; i < NUM_WHEELS; i++) begin
			padj = p_s4[i] + (p_s4[i][57] ? 58'sd16777215 : 58'sd0);
			q    = 34'(padj >>> 24);
			if (q > 34'sd32767) begin
				w_c[i] = 16'sh7fff;
			end else if (q < -34'sd32768) begin
				w_c[i] = 16'sh8000;
			end else begin
				w_c[i] = q[15:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[5]) begin
			w_s5 <= w_c;
		end
	end

	// s6: magnitudes and peak, -32768 reads as 32768
	logic [15:0]            abs_c [NUM_WHEELS];
	logic [15:0]            peak_lo_c, peak_hi_c, peak_c;
	logic [15:0]            abs_s6 [NUM_WHEELS];
	logic [NUM_WHEELS-1:0]  neg_s6;
	logic signed [15:0]     wheel_s6 [NUM_WHEELS];
	logic [15:0]            peak_s6;
	logic                   scaled_s6;

	always_comb begin
		for (int i = 0; i < NUM_WHEELS; i++) begin
			abs_c[i] = w_s5[i][15] ? (~w_s5[i] + 16'd1) : w_s5[i];
		end
		peak_lo_c = (abs_c[0] > abs_c[1]) ? abs_c[0] : abs_c[1];
		peak_hi_c = (abs_c[2] > abs_c[3]) ? abs_c[2] : abs_c[3];
		peak_c    = (peak_lo_c > peak_hi_c) ? peak_lo_c : peak_hi_c;
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			for (int i = 0; i < NUM_WHEELS; i++) begin
				neg_s6[i] <= w_s5[i][15];
			end
			abs_s6    <= abs_c;
			wheel_s6  <= w_s5;
			peak_s6   <= peak_c;
			scaled_s6 <= peak_c > {1'b0, max_wheel_rpm_q};
		end
	end

	// s7: dividend |w| * limit, below 2^30
	div_stage_t d_s7;

	always_ff @(posedge clk) begin
		if (en[7]) begin
			for (int i = 0; i < NUM_WHEELS; i++) begin
				d_s7.lane[i].rem <= 30'({14'b0, abs_s6[i]} * {15'b0, max_wheel_rpm_q});
				d_s7.lane[i].quo <= '0;
				d_s7.wheel[i]    <= wheel_s6[i];
			end
			d_s7.divisor <= peak_s6;
			d_s7.neg     <= neg_s6;
			d_s7.scaled  <= scaled_s6;
		end
	end

	// divider pipeline
	div_stage_t div_d [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		if (k == 0) begin : g_first
			mwsm_div_stage #(
				.TOP_BIT (QUO_W - 1)
			) u_stage (
				.clk       (clk),
				.arst_n    (arst_n),
				.en        (en[8]),
				.in_valid  (vld_s7),
				.in_data   (d_s7),
				.out_valid (div_vld[0]),
				.out_data  (div_d[0])
			);
		end else begin : g_next
			mwsm_div_stage #(
				.TOP_BIT (QUO_W - 1 - k * BITS_PER_STAGE)
			) u_stage (
				.clk       (clk),
				.arst_n    (arst_n),
				.en        (en[8+k]),
				.in_valid  (div_vld[k-1]),
				.in_data   (div_d[k-1]),
				.out_valid (div_vld[k]),
				.out_data  (div_d[k])
			);
		end
	end

	// output stage: signed quotient when scaled, else the wheel as it was
	div_stage_t         div_last;
	logic signed [15:0] wheel_s13 [NUM_WHEELS];
	logic               scaled_s13;

	assign div_last = div_d[DIV_STAGES-1];

	always_ff @(posedge clk) begin
		if (en[NSTG]) begin
			for (int i = 0; i < NUM_WHEELS; i++) begin
				if (div_last.scaled) begin
					wheel_s13[i] <= div_last.neg[i] ? -$signed({1'b0, div_last.lane[i].quo})
						: $signed({1'b0, div_last.lane[i].quo});
				end else begin
					wheel_s13[i] <= $signed(div_last.wheel[i]);
				end
			end
			scaled_s13 <= div_last.scaled;
		end
	end

	assign wheel.valid             = vld_s13;
	assign wheel.wheel_front_right = wheel_s13[0];
	assign wheel.wheel_front_left  = wheel_s13[1];
	assign wheel.wheel_back_left   = wheel_s13[2];
	assign wheel.wheel_back_right  = wheel_s13[3];
	assign wheel.was_scaled        = scaled_s13;

	function automatic logic in_lim(logic signed [15:0] w, logic [14:0] l);
		in_lim = (w <= $signed({1'b0, l})) && (w >= -$signed({1'b0, l}));
	endfunction

	// every delivered wheel set respects the rpm limit
	a_out_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		wheel.valid |-> in_lim(wheel.wheel_front_right, max_wheel_rpm_q)
			&& in_lim(wheel.wheel_front_left, max_wheel_rpm_q)
			&& in_lim(wheel.wheel_back_left, max_wheel_rpm_q)
			&& in_lim(wheel.wheel_back_right, max_wheel_rpm_q))
		else $error("wheel rpm beyond limit");

	// scaled quotients never exceed the limit
	a_quo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		div_vld[DIV_STAGES-1] && div_last.scaled |->
			div_last.lane[0].quo <= max_wheel_rpm_q && div_last.lane[1].quo <= max_wheel_rpm_q
			&& div_last.lane[2].quo <= max_wheel_rpm_q
			&& div_last.lane[3].quo <= max_wheel_rpm_q)
		else $error("divider quotient above limit");

	// an accepted item always lands in the first stage
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> vld_s1)
		else $error("accepted item lost at entry");

	// a scaled set always has a nonzero peak
	a_scaled_peak: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s7 && d_s7.scaled |-> d_s7.divisor != '0)
		else $error("scaling with zero peak");

endmodule

// ===== hdl/mwsm_div_stage.sv =====
module mwsm_div_stage
	import mwsm_pkg::*;
#(
	parameter int unsigned TOP_BIT = QUO_W - 1
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       in_valid,
	input  div_stage_t in_data,
	output logic       out_valid,
	output div_stage_t out_data
);

	localparam int unsigned DSH_W = DIVD_W + 1;

	div_stage_t nxt;

	// restoring division, BITS_PER_STAGE quotient bits per stage, all lanes share the divisor
	always_comb begin
		logic [DIVD_W-1:0] rem;
		logic [QUO_W-1:0]  quo;
		logic [DSH_W-1:0]  sh;
		nxt = in_data;
		for (int l = 0; l < NUM_WHEELS; l++) begin
			rem = in_data.lane[l].rem;
			quo = in_data.lane[l].quo;
			for (int j = 0; j < BITS_PER_STAGE; j++) begin
				sh = DSH_W'(in_data.divisor) << (TOP_BIT - j);
				if ({1'b0, rem} >= sh) begin
					rem = rem - sh[DIVD_W-1:0];
					quo[TOP_BIT-j] = 1'b1;
				end
			end
			nxt.lane[l].rem = rem;
			nxt.lane[l].quo = quo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data <= nxt;
		end
	end

endmodule
